/* src/fsa_pkg.sv */
// Shared types, constants and state codes for the fraction sum accumulator.
package fsa_pkg;

  localparam int DEF_WIDTH    = 32;
  localparam int DEF_IN_WIDTH = 16;
  localparam int OUT_W        = 32;
  localparam int STAT_W       = 2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [DEF_IN_WIDTH-1:0] add_numerator;
    logic [DEF_IN_WIDTH-1:0] add_denominator;
    logic                    restart;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0]  whole_part;
    logic [OUT_W-1:0]  frac_numerator;
    logic [OUT_W-1:0]  frac_denominator;
    logic [STAT_W-1:0] status;
  } out_item_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_IN,     // n / d
    S_GCD1,       // gcd(den, d)
    S_DIV_Q,      // q = den / g
    S_MUL_LCM,    // lcm = q * d
    S_DIV_LA,     // lcm / den
    S_MUL_A,      // a = num * (lcm / den)
    S_MUL_B,      // b = rem * q  (lcm / d == q)
    S_COMBINE,
    S_GCD2,
    S_DIV_NUM,
    S_DIV_DEN,
    S_OUT
  } seq_state_t;

  // Operation codes for requests to the bit-serial arithmetic unit
  typedef enum logic [1:0] {
    OP_DIV,
    OP_MUL,
    OP_GCD
  } arith_op_t;

endpackage

/* src/fraction_sum_accumulator_unit.sv */
// Top level: running mixed-number sum of fractions with gcd reduction.
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one fraction per
//   transaction plus a restart flag. Output channel (out_valid / out_stall /
//   out_data) returns one transaction per input: whole part, reduced
//   fraction and status (ok, zero denominator, sticky overflow).
// Sequencing:
//   One item at a time. Each item runs through one shared bit-serial unit:
//   eight WIDTH-step divides/multiplies and two binary gcds of up to about
//   2*WIDTH steps each. Rejected items and items that overflow skip the
//   remaining steps and go straight to the result.
//   The input is taken again as soon as the result sits in the output
//   register, so the next item computes while that result waits.
// Reset:
//   rst (synchronous) clears the sum to 0 0/1 and the overflow flag and
//   drops any pending result.
// Stall:
//   While out_stall is high the result register holds; a finished next
//   item waits in the sequencer until the register is free.
module fraction_sum_accumulator_unit #(
  parameter int WIDTH    = fsa_pkg::DEF_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  fsa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fsa_pkg::out_item_t out_data
);

  localparam logic [WIDTH-1:0]  WMAX = '1;
  localparam logic [31:0]       WHOLE_MAX = 32'hFFFF_FFFF;

  fsa_pkg::seq_state_t state, state_next;

  // Sum state
  logic [31:0]      sum_whole;
  logic [WIDTH-1:0] sum_num;
  logic [WIDTH-1:0] sum_den;
  logic             overflowed;

  // Item working registers
  logic [WIDTH-1:0] n_in, d_in, in_whole, in_rem, g, q, lcm, la, num_r;
  logic [2*WIDTH-1:0] a_r;
  logic [1:0]       stat;

  // Arithmetic unit
  logic               a_start, a_done;
  fsa_pkg::arith_op_t a_op;
  logic [WIDTH-1:0]   a_opa, a_opb;
  logic [2*WIDTH-1:0] a_res;
  logic [WIDTH-1:0]   a_rem;
  logic               issued;

  // Fraction combine
  logic [2*WIDTH-1:0] lcm_sub_b;
  logic [2*WIDTH-1:0] num_sum;
  logic [33:0]        w_sum;
  logic               carry;

  fsa_arith #(.W(WIDTH)) u_arith (
    .clk(clk), .rst(rst), .start(a_start), .op(a_op), .opa(a_opa), .opb(a_opb),
    .done(a_done), .res(a_res), .rem(a_rem)
  );

  assign in_stall = (state != fsa_pkg::S_IDLE);

  // Operand selection per state
  always_comb begin
    a_op  = fsa_pkg::OP_DIV;
    a_opa = '0;
    a_opb = '0;
    unique case (state)
      fsa_pkg::S_DIV_IN:  begin a_opa = n_in;    a_opb = d_in; end
      fsa_pkg::S_GCD1:    begin a_op = fsa_pkg::OP_GCD; a_opa = sum_den; a_opb = d_in; end
      fsa_pkg::S_DIV_Q:   begin a_opa = sum_den; a_opb = g; end
      fsa_pkg::S_MUL_LCM: begin a_op = fsa_pkg::OP_MUL; a_opa = q; a_opb = d_in; end
      fsa_pkg::S_DIV_LA:  begin a_opa = lcm;     a_opb = sum_den; end
      fsa_pkg::S_MUL_A:   begin a_op = fsa_pkg::OP_MUL; a_opa = sum_num; a_opb = la; end
      fsa_pkg::S_MUL_B:   begin a_op = fsa_pkg::OP_MUL; a_opa = in_rem; a_opb = q; end
      fsa_pkg::S_GCD2:    begin a_op = fsa_pkg::OP_GCD; a_opa = num_r; a_opb = lcm; end
      fsa_pkg::S_DIV_NUM: begin a_opa = num_r;   a_opb = g; end
      fsa_pkg::S_DIV_DEN: begin a_opa = lcm;     a_opb = g; end
      default: ;
    endcase
  end

  assign a_start = !issued && (state != fsa_pkg::S_IDLE) && (state != fsa_pkg::S_COMBINE)
                   && (state != fsa_pkg::S_OUT);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      fsa_pkg::S_IDLE: begin
        if (in_valid) begin
          // Sticky overflow and zero denominator skip straight to the result
          if ((overflowed && !in_data.restart) || (in_data.add_denominator == '0)) begin
            state_next = fsa_pkg::S_OUT;
          end else begin
            state_next = fsa_pkg::S_DIV_IN;
          end
        end
      end
      fsa_pkg::S_DIV_IN:  if (a_done) state_next = fsa_pkg::S_GCD1;
      fsa_pkg::S_GCD1:    if (a_done) state_next = fsa_pkg::S_DIV_Q;
      fsa_pkg::S_DIV_Q:   if (a_done) state_next = fsa_pkg::S_MUL_LCM;
      fsa_pkg::S_MUL_LCM: begin
        if (a_done) begin
          if (a_res > {{WIDTH{1'b0}}, WMAX}) state_next = fsa_pkg::S_OUT;
          else state_next = fsa_pkg::S_DIV_LA;
        end
      end
      fsa_pkg::S_DIV_LA:  if (a_done) state_next = fsa_pkg::S_MUL_A;
      fsa_pkg::S_MUL_A:   if (a_done) state_next = fsa_pkg::S_MUL_B;
      fsa_pkg::S_MUL_B:   if (a_done) state_next = fsa_pkg::S_COMBINE;
      fsa_pkg::S_COMBINE: begin
        if (w_sum > 34'(WHOLE_MAX)) state_next = fsa_pkg::S_OUT;
        else state_next = fsa_pkg::S_GCD2;
      end
      fsa_pkg::S_GCD2:    if (a_done) state_next = fsa_pkg::S_DIV_NUM;
      fsa_pkg::S_DIV_NUM: if (a_done) state_next = fsa_pkg::S_DIV_DEN;
      fsa_pkg::S_DIV_DEN: if (a_done) state_next = fsa_pkg::S_OUT;
      fsa_pkg::S_OUT:     if (!out_valid || !out_stall) state_next = fsa_pkg::S_IDLE;
      default:            state_next = fsa_pkg::S_IDLE;
    endcase
  end

  assign lcm_sub_b = {{WIDTH{1'b0}}, lcm} - a_res;
  assign carry     = (a_r >= lcm_sub_b);
  assign num_sum   = carry ? (a_r - lcm_sub_b) : (a_r + a_res);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fsa_pkg::S_IDLE;
      issued     <= 1'b0;
      out_valid  <= 1'b0;
      sum_whole  <= '0;
      sum_num    <= '0;
      sum_den    <= WIDTH'(1);
      overflowed <= 1'b0;
    end else begin
      state <= state_next;
      if (a_start) issued <= 1'b1;
      if (a_done)  issued <= 1'b0;

      // Result register fills from the sequencer and empties on acceptance
      if (state == fsa_pkg::S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (state)
        fsa_pkg::S_IDLE: begin
          if (in_valid) begin
            n_in <= WIDTH'(in_data.add_numerator);
            d_in <= WIDTH'(in_data.add_denominator);
            if (in_data.restart) begin
              sum_whole  <= '0;
              sum_num    <= '0;
              sum_den    <= WIDTH'(1);
              overflowed <= 1'b0;
            end
            // Sticky overflow wins over the zero-denominator check
            priority if (overflowed && !in_data.restart) begin
              stat <= fsa_pkg::ST_OVERFLOW;
            end else if (in_data.add_denominator == '0) begin
              stat <= fsa_pkg::ST_ZERO_DEN;
            end else begin
              stat <= fsa_pkg::ST_OK;
            end
          end
        end
        fsa_pkg::S_DIV_IN: if (a_done) begin
          in_whole <= a_res[WIDTH-1:0];
          in_rem   <= a_rem;
        end
        fsa_pkg::S_GCD1: if (a_done) g <= a_res[WIDTH-1:0];
        fsa_pkg::S_DIV_Q: if (a_done) q <= a_res[WIDTH-1:0];
        fsa_pkg::S_MUL_LCM: if (a_done) begin
          if (a_res > {{WIDTH{1'b0}}, WMAX}) begin
            overflowed <= 1'b1;
            sum_whole  <= WHOLE_MAX;
            stat       <= fsa_pkg::ST_OVERFLOW;
          end
          lcm <= a_res[WIDTH-1:0];
        end
        fsa_pkg::S_DIV_LA: if (a_done) la <= a_res[WIDTH-1:0];
        fsa_pkg::S_MUL_A: if (a_done) a_r <= a_res;
        fsa_pkg::S_MUL_B: if (a_done) begin
          num_r <= num_sum[WIDTH-1:0];
          w_sum <= 34'(sum_whole) + 34'(in_whole) + 34'(carry);
        end
        fsa_pkg::S_COMBINE: begin
          if (w_sum > 34'(WHOLE_MAX)) begin
            overflowed <= 1'b1;
            sum_whole  <= WHOLE_MAX;
            stat       <= fsa_pkg::ST_OVERFLOW;
          end else begin
            sum_whole <= w_sum[31:0];
          end
        end
        fsa_pkg::S_GCD2: if (a_done) g <= a_res[WIDTH-1:0];
        fsa_pkg::S_DIV_NUM: if (a_done) sum_num <= a_res[WIDTH-1:0];
        fsa_pkg::S_DIV_DEN: if (a_done) sum_den <= a_res[WIDTH-1:0];
        fsa_pkg::S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_data.whole_part       <= sum_whole;
            out_data.frac_numerator   <= fsa_pkg::OUT_W'(sum_num);
            out_data.frac_denominator <= fsa_pkg::OUT_W'(sum_den);
            out_data.status           <= stat;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* src/fsa_arith.sv */
// Bit-serial arithmetic unit: restoring divide, shift-add multiply, binary gcd.
module fsa_arith #(
  parameter int W = fsa_pkg::DEF_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  fsa_pkg::arith_op_t  op,
  input  logic [W-1:0]        opa,
  input  logic [W-1:0]        opb,
  output logic                done,
  output logic [2*W-1:0]      res,   // quotient / product / gcd
  output logic [W-1:0]        rem
);

  localparam int CW = $clog2(2*W+1);

  fsa_pkg::arith_op_t cur_op;
  logic            busy;
  logic [CW-1:0]   cnt;
  logic [2*W-1:0]  acc;
  logic [2*W-1:0]  mcand;
  logic [W-1:0]    x;
  logic [W-1:0]    y;
  logic [W:0]      r;
  logic [CW-1:0]   shift;

  logic [W:0]      r_trial;
  logic [W:0]      r_sh;
  logic [W-1:0]    gx_next;
  logic [W-1:0]    gy_next;
  logic            gcd_end;

  // One divide step: shift in the next dividend bit and try a subtract
  assign r_sh    = {r[W-1:0], x[W-1]};
  assign r_trial = r_sh - {1'b0, y};

  // One binary-gcd step on x and y
  always_comb begin
    gx_next = x;
    gy_next = y;
    gcd_end = 1'b0;
    if (x == '0 || y == '0) begin
      gcd_end = 1'b1;
    end else if (!x[0] && !y[0]) begin
      gx_next = x >> 1;
      gy_next = y >> 1;
    end else if (!x[0]) begin
      gx_next = x >> 1;
    end else if (!y[0]) begin
      gy_next = y >> 1;
    end else if (x >= y) begin
      gx_next = (x - y) >> 1;
    end else begin
      gy_next = (y - x) >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy   <= 1'b1;
        cur_op <= op;
        cnt    <= '0;
        shift  <= '0;
        x      <= opa;
        y      <= opb;
        r      <= '0;
        acc    <= '0;
        mcand  <= {{W{1'b0}}, opa};
      end else if (busy) begin
        unique case (cur_op)
          fsa_pkg::OP_DIV: begin
            if (r_trial[W]) begin
              r <= r_sh;
              x <= {x[W-2:0], 1'b0};
            end else begin
              r <= r_trial;
              x <= {x[W-2:0], 1'b1};
            end
            cnt <= cnt + 1'b1;
            if (cnt == CW'(W-1)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          fsa_pkg::OP_MUL: begin
            if (y[0]) acc <= acc + mcand;
            mcand <= {mcand[2*W-2:0], 1'b0};
            y     <= y >> 1;
            cnt   <= cnt + 1'b1;
            if (cnt == CW'(W-1)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: begin
            if (gcd_end) begin
              acc  <= ({{W{1'b0}}, x | y}) << shift;
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              if (!x[0] && !y[0]) shift <= shift + 1'b1;
              x <= gx_next;
              y <= gy_next;
            end
          end
        endcase
      end
    end
  end

  assign res = (cur_op == fsa_pkg::OP_DIV) ? {{W{1'b0}}, x} : acc;
  assign rem = r[W-1:0];

endmodule
